// ===== hw/rtl/matinv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matinv_pkg
// Shared constants and types for the 3x3 fixed-point matrix inverse.
// ----------------------------------------------------------------------------
package matinv_pkg;

  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int MAT_DIM        = 3;
  localparam int NUM_ELEM       = MAT_DIM * MAT_DIM;

  // Per-word sideband that rides along the divider pipeline.
  typedef struct packed {
    logic                singular;
    logic [NUM_ELEM-1:0] neg;
  } side_t;

endpackage
`default_nettype wire

// ===== hw/rtl/matinv_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matinv_in_if
// Input channel: one 3x3 matrix per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface matinv_in_if #(
  parameter int W = matinv_pkg::ELEM_WIDTH_DEF
);
  logic         valid;
  logic         ready;
  logic [W-1:0] a_r0c0;
  logic [W-1:0] a_r0c1;
  logic [W-1:0] a_r0c2;
  logic [W-1:0] a_r1c0;
  logic [W-1:0] a_r1c1;
  logic [W-1:0] a_r1c2;
  logic [W-1:0] a_r2c0;
  logic [W-1:0] a_r2c1;
  logic [W-1:0] a_r2c2;

  modport source (
    output valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2, a_r2c0, a_r2c1, a_r2c2,
    input  ready
  );
  modport sink (
    input  valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2, a_r2c0, a_r2c1, a_r2c2,
    output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/matinv_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matinv_out_if
// Result channel: one inverse matrix plus status flags per word.
// ----------------------------------------------------------------------------
interface matinv_out_if #(
  parameter int W = matinv_pkg::ELEM_WIDTH_DEF
);
  logic         valid;
  logic         ready;
  logic [W-1:0] inv_r0c0;
  logic [W-1:0] inv_r0c1;
  logic [W-1:0] inv_r0c2;
  logic [W-1:0] inv_r1c0;
  logic [W-1:0] inv_r1c1;
  logic [W-1:0] inv_r1c2;
  logic [W-1:0] inv_r2c0;
  logic [W-1:0] inv_r2c1;
  logic [W-1:0] inv_r2c2;
  logic         singular;
  logic         saturated;

  modport source (
    output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
           inv_r2c0, inv_r2c1, inv_r2c2, singular, saturated,
    input  ready
  );
  modport sink (
    input  valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
           inv_r2c0, inv_r2c1, inv_r2c2, singular, saturated,
    output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/matinv_div_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matinv_div_pipe
// Nine pipelined restoring dividers sharing one divisor, one quotient bit per
// stage, plus an overflow compare up front.
// ----------------------------------------------------------------------------
module matinv_div_pipe #(
  parameter int ELEM_WIDTH = matinv_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = matinv_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [2*ELEM_WIDTH+2*FRAC_BITS:0]    num [matinv_pkg::NUM_ELEM],
  input  logic [3*ELEM_WIDTH+2:0]              dmag,
  input  matinv_pkg::side_t                    side_in,
  output logic                                 out_valid,
  output logic [ELEM_WIDTH-1:0]                quo [matinv_pkg::NUM_ELEM],
  output logic [matinv_pkg::NUM_ELEM-1:0]      big,
  output matinv_pkg::side_t                    side_out
);
  import matinv_pkg::*;

  localparam int E  = ELEM_WIDTH;
  localparam int NW = 2 * E + 2 * FRAC_BITS + 1;
  localparam int DW = 3 * E + 3;
  localparam int W  = (NW > DW + E) ? NW : DW + E;

  logic                v_r    [0:E];
  side_t               side_r [0:E];
  logic [NUM_ELEM-1:0] big_r  [0:E];
  logic [W-1:0]        rem_r  [0:E-1][NUM_ELEM];
  logic [DW-1:0]       dmag_r [0:E-1];
  logic [E-1:0]        q_r    [1:E][NUM_ELEM];

  // Stage 0: a quotient of 2^E or more can only saturate, so flag it here
  // and let the remaining stages produce the low E quotient bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      dmag_r[0] <= dmag;
      for (int i = 0; i < NUM_ELEM; i++) begin
        rem_r[0][i] <= W'(num[i]);
        big_r[0][i] <= W'(num[i]) >= (W'(dmag) << E);
      end
    end
  end

  for (genvar s = 1; s <= E; s++) begin : g_stage
    localparam int K = E - s;
    logic [W-1:0]        trial;
    logic [NUM_ELEM-1:0] ge;

    assign trial = W'(dmag_r[s-1]) << K;

    always_comb begin
      for (int i = 0; i < NUM_ELEM; i++) begin
        ge[i] = rem_r[s-1][i] >= trial;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s] <= side_r[s-1];
        big_r[s]  <= big_r[s-1];
      end
    end

    for (genvar i = 0; i < NUM_ELEM; i++) begin : g_lane
      if (s == 1) begin : g_first
        always_ff @(posedge clk) begin
          if (en) begin
            q_r[s][i] <= E'(ge[i]);
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (en) begin
            q_r[s][i] <= {q_r[s-1][i][E-2:0], ge[i]};
          end
        end
      end
    end

    if (s < E) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          dmag_r[s] <= dmag_r[s-1];
          for (int i = 0; i < NUM_ELEM; i++) begin
            rem_r[s][i] <= ge[i] ? rem_r[s-1][i] - trial : rem_r[s-1][i];
          end
        end
      end
    end
  end

  assign out_valid = v_r[E];
  assign side_out  = side_r[E];
  assign big       = big_r[E];
  assign quo       = q_r[E];

endmodule
`default_nettype wire

// ===== hw/rtl/matrix_inverse_3x3_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_unit
// 3x3 signed fixed-point matrix inverse by the adjugate, fully pipelined.
// ----------------------------------------------------------------------------
// One matrix word is taken every clock while the output is not stalled: five
// stages register the input and form the element products, cofactors,
// determinant partial products and determinant, one stage takes magnitudes,
// and a divider of ELEM_WIDTH + 1 stages makes an overflow compare and then
// one quotient bit per stage for all nine entries at once, before the output
// register. The whole pipeline holds while a finished word waits on the
// output. Quotients round toward zero and saturate; a zero determinant gives
// an all-zero matrix with singular set.
module matrix_inverse_3x3_unit #(
  parameter int ELEM_WIDTH = matinv_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = matinv_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  matinv_in_if.sink    in_ch,
  matinv_out_if.source out_ch
);
  import matinv_pkg::*;

  localparam int E  = ELEM_WIDTH;
  localparam int PW = 2 * E;
  localparam int CW = 2 * E + 1;
  localparam int DW = 3 * E + 3;
  localparam int NW = CW + 2 * FRAC_BITS;
  localparam logic [E-1:0] LIM  = {1'b1, {(E-1){1'b0}}};
  localparam logic [E-1:0] MAXP = {1'b0, {(E-1){1'b1}}};

  logic adv;
  logic out_valid_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  logic signed [E-1:0] a_in [NUM_ELEM];
  always_comb begin
    a_in[0] = in_ch.a_r0c0;
    a_in[1] = in_ch.a_r0c1;
    a_in[2] = in_ch.a_r0c2;
    a_in[3] = in_ch.a_r1c0;
    a_in[4] = in_ch.a_r1c1;
    a_in[5] = in_ch.a_r1c2;
    a_in[6] = in_ch.a_r2c0;
    a_in[7] = in_ch.a_r2c1;
    a_in[8] = in_ch.a_r2c2;
  end

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // Stage 1: input register.
  logic signed [E-1:0] e1_r [NUM_ELEM];
  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r <= a_in;
    end
  end

  // Stage 2: the two minor products of every cofactor.
  logic signed [PW-1:0] p1_r [NUM_ELEM];
  logic signed [PW-1:0] p2_r [NUM_ELEM];
  logic signed [E-1:0]  e2_r [MAT_DIM];
  logic signed [CW-1:0] cof_r [NUM_ELEM];
  logic signed [E-1:0]  e3_r [MAT_DIM];

  for (genvar gi = 0; gi < NUM_ELEM; gi++) begin : g_cof
    localparam int R  = gi / MAT_DIM;
    localparam int C  = gi % MAT_DIM;
    localparam int R1 = (R == 0) ? 1 : 0;
    localparam int R2 = (R == 2) ? 1 : 2;
    localparam int C1 = (C == 0) ? 1 : 0;
    localparam int C2 = (C == 2) ? 1 : 2;
    localparam bit ODD = ((R + C) % 2) == 1;

    always_ff @(posedge clk) begin
      if (adv) begin
        p1_r[gi] <= e1_r[R1*MAT_DIM+C1] * e1_r[R2*MAT_DIM+C2];
        p2_r[gi] <= e1_r[R1*MAT_DIM+C2] * e1_r[R2*MAT_DIM+C1];
      end
    end

    // Stage 3: cofactor with its checkerboard sign.
    always_ff @(posedge clk) begin
      if (adv) begin
        if (ODD) begin
          cof_r[gi] <= CW'(p2_r[gi]) - CW'(p1_r[gi]);
        end else begin
          cof_r[gi] <= CW'(p1_r[gi]) - CW'(p2_r[gi]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < MAT_DIM; c++) begin
        e2_r[c] <= e1_r[c];
        e3_r[c] <= e2_r[c];
      end
    end
  end

  // Stage 4: row 0 times its cofactors, each cofactor split into a low
  // unsigned half and a high signed half to keep the multipliers narrow.
  logic signed [CW-1:0] dlo_r [MAT_DIM];
  logic signed [CW-1:0] dhi_r [MAT_DIM];
  logic signed [CW-1:0] cof4_r [NUM_ELEM];

  always_ff @(posedge clk) begin
    if (adv) begin
      cof4_r <= cof_r;
      for (int c = 0; c < MAT_DIM; c++) begin
        dlo_r[c] <= $signed({1'b0, cof_r[c][E-1:0]}) * e3_r[c];
        dhi_r[c] <= $signed(cof_r[c][CW-1:E]) * e3_r[c];
      end
    end
  end

  // Stage 5: determinant.
  logic signed [DW-1:0] det_sum;
  logic signed [DW-1:0] det_r;
  logic signed [CW-1:0] cof5_r [NUM_ELEM];

  always_comb begin
    det_sum = '0;
    for (int c = 0; c < MAT_DIM; c++) begin
      det_sum = det_sum + (DW'(dhi_r[c]) <<< E) + DW'(dlo_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det_r  <= det_sum;
      cof5_r <= cof4_r;
    end
  end

  // Stage 6: magnitudes, signs and transposition for the divider.
  logic          dneg;
  logic [DW-1:0] dmag;
  logic [NW-1:0] num  [NUM_ELEM];
  side_t         side;

  logic [NW-1:0] num6_r  [NUM_ELEM];
  logic [DW-1:0] dmag6_r;
  side_t         side6_r;

  assign dneg = det_r[DW-1];
  assign dmag = dneg ? DW'(-det_r) : DW'(det_r);
  assign side.singular = (det_r == '0);

  for (genvar gi = 0; gi < NUM_ELEM; gi++) begin : g_num
    localparam int SRC = (gi % MAT_DIM) * MAT_DIM + (gi / MAT_DIM);
    logic          csgn;
    logic [CW-1:0] cmag;

    assign csgn        = cof5_r[SRC][CW-1];
    assign cmag        = csgn ? CW'(-cof5_r[SRC]) : CW'(cof5_r[SRC]);
    assign num[gi]     = NW'(cmag) << (2 * FRAC_BITS);
    assign side.neg[gi] = csgn ^ dneg;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num6_r  <= num;
      dmag6_r <= dmag;
      side6_r <= side;
    end
  end

  logic                d_valid;
  logic [E-1:0]        d_quo [NUM_ELEM];
  logic [NUM_ELEM-1:0] d_big;
  side_t               d_side;

  matinv_div_pipe #(
    .ELEM_WIDTH (ELEM_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v6_r),
    .num       (num6_r),
    .dmag      (dmag6_r),
    .side_in   (side6_r),
    .out_valid (d_valid),
    .quo       (d_quo),
    .big       (d_big),
    .side_out  (d_side)
  );

  // Saturation and packing into the output register.
  logic [E-1:0]        res_nxt [NUM_ELEM];
  logic [NUM_ELEM-1:0] clip;
  logic [E-1:0]        inv_r [NUM_ELEM];
  logic                singular_r;
  logic                sat_r;

  always_comb begin
    for (int i = 0; i < NUM_ELEM; i++) begin
      clip[i]    = 1'b0;
      res_nxt[i] = '0;
      if (!d_side.singular) begin
        if (d_side.neg[i]) begin
          if (d_big[i] || d_quo[i] > LIM) begin
            clip[i]    = 1'b1;
            res_nxt[i] = LIM;
          end else begin
            res_nxt[i] = E'(-d_quo[i]);
          end
        end else begin
          if (d_big[i] || d_quo[i] >= LIM) begin
            clip[i]    = 1'b1;
            res_nxt[i] = MAXP;
          end else begin
            res_nxt[i] = d_quo[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inv_r      <= res_nxt;
      singular_r <= d_side.singular;
      sat_r      <= |clip;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.inv_r0c0  = inv_r[0];
  assign out_ch.inv_r0c1  = inv_r[1];
  assign out_ch.inv_r0c2  = inv_r[2];
  assign out_ch.inv_r1c0  = inv_r[3];
  assign out_ch.inv_r1c1  = inv_r[4];
  assign out_ch.inv_r1c2  = inv_r[5];
  assign out_ch.inv_r2c0  = inv_r[6];
  assign out_ch.inv_r2c1  = inv_r[7];
  assign out_ch.inv_r2c2  = inv_r[8];
  assign out_ch.singular  = singular_r;
  assign out_ch.saturated = sat_r;

endmodule
`default_nettype wire

// ===== dv/matinv_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matinv_tb_pkg
// Word types shared by the matrix inverse testbench.
// ----------------------------------------------------------------------------
package matinv_tb_pkg;

  localparam int EW = matinv_pkg::ELEM_WIDTH_DEF;
  localparam int FB = matinv_pkg::FRAC_BITS_DEF;
  localparam int NE = matinv_pkg::NUM_ELEM;

  typedef logic signed [EW-1:0] elem_t;

  typedef struct {
    elem_t a [NE];
  } matrix_t;

  typedef struct {
    elem_t inv [NE];
    logic  singular;
    logic  saturated;
  } inverse_t;

endpackage

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the 3x3 fixed-point matrix inverse against an exact adjugate model.
// ----------------------------------------------------------------------------
// Directed matrices cover identity, singular, extreme and saturating cases;
// random matrices follow. Both sides pause at random, and every result word
// is compared field by field with the oldest predicted inverse.
module testbench;
  import matinv_tb_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   sent_count;
  inverse_t expected_q[$];

  matinv_in_if  #(.W(EW)) in_ch ();
  matinv_out_if #(.W(EW)) out_ch ();

  matrix_inverse_3x3_unit #(.ELEM_WIDTH(EW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // Exact inverse: cofactors at full width, quotient truncated, then clipped.
  function automatic inverse_t predict_inverse(matrix_t m);
    logic signed [255:0] e [3][3];
    logic signed [255:0] cof [3][3];
    logic signed [255:0] det, num, q;
    logic signed [255:0] hi, lo;
    inverse_t res;
    int r1, r2, c1, c2;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        e[r][c] = m.a[r*3+c];
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        r1 = (r == 0) ? 1 : 0; r2 = (r == 2) ? 1 : 2;
        c1 = (c == 0) ? 1 : 0; c2 = (c == 2) ? 1 : 2;
        cof[r][c] = e[r1][c1] * e[r2][c2] - e[r1][c2] * e[r2][c1];
        if ((r + c) % 2) cof[r][c] = -cof[r][c];
      end
    det = e[0][0]*cof[0][0] + e[0][1]*cof[0][1] + e[0][2]*cof[0][2];
    res.singular = (det == 0);
    res.saturated = 1'b0;
    hi = (256'sd1 <<< (EW-1)) - 1;
    lo = -(256'sd1 <<< (EW-1));
    for (int k = 0; k < NE; k++) begin
      if (res.singular) begin
        res.inv[k] = '0;
      end else begin
        num = cof[k%3][k/3] <<< (2*FB);
        q = num / det;
        if (q > hi) begin
          q = hi; res.saturated = 1'b1;
        end else if (q < lo) begin
          q = lo; res.saturated = 1'b1;
        end
        res.inv[k] = q[EW-1:0];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int idx, logic [EW-1:0] got,
                                 logic [EW-1:0] want);
    $display("MISMATCH %s[%0d]: got %h expected %h", what, idx, got, want);
    fail_count++;
  endtask

  // Valid stays high into the next word when no gap is drawn, so it is
  // dropped only before a wait and once after the last word.
  task automatic send_matrix(matrix_t m);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.a_r0c0 <= m.a[0]; in_ch.a_r0c1 <= m.a[1]; in_ch.a_r0c2 <= m.a[2];
    in_ch.a_r1c0 <= m.a[3]; in_ch.a_r1c1 <= m.a[4]; in_ch.a_r1c2 <= m.a[5];
    in_ch.a_r2c0 <= m.a[6]; in_ch.a_r2c1 <= m.a[7]; in_ch.a_r2c2 <= m.a[8];
    do @(posedge clk); while (!in_ch.ready);
    expected_q.insert(expected_q.size(), predict_inverse(m));
    sent_count++;
  endtask

  function automatic elem_t rand_elem(int kind);
    case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
      2: return $signed($urandom_range(0, 255)) - 128;
      default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  task automatic test_directed();
    matrix_t m;
    // Identity and scaled identity.
    foreach (m.a[k]) m.a[k] = (k % 4 == 0) ? 32'sh0001_0000 : 0;
    send_matrix(m);
    foreach (m.a[k]) m.a[k] = (k % 4 == 0) ? -32'sh0002_0000 : 0;
    send_matrix(m);
    // All zero and rank-one give a zero determinant.
    foreach (m.a[k]) m.a[k] = 0;
    send_matrix(m);
    foreach (m.a[k]) m.a[k] = 32'sh0001_0000 * (k / 3 + 1);
    send_matrix(m);
    // Tiny determinant saturates; huge one gives quotients near zero.
    foreach (m.a[k]) m.a[k] = (k % 4 == 0) ? 1 : 0;
    send_matrix(m);
    foreach (m.a[k]) m.a[k] = (k % 4 == 0) ? -1 : 0;
    send_matrix(m);
    foreach (m.a[k]) m.a[k] = (k % 4 == 0) ? 32'sh7FFF_FFFF : 0;
    send_matrix(m);
    foreach (m.a[k]) m.a[k] = (k % 4 == 0) ? 32'sh8000_0000 : 0;
    send_matrix(m);
    foreach (m.a[k]) m.a[k] = 32'sh8000_0000;
    send_matrix(m);
    foreach (m.a[k]) m.a[k] = (k % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    send_matrix(m);
    foreach (m.a[k]) m.a[k] = -1;
    send_matrix(m);
    // Permutation with mixed signs.
    foreach (m.a[k]) m.a[k] = 0;
    m.a[1] = 32'sh0001_0000; m.a[5] = -32'sh0003_0000; m.a[6] = 32'sh0000_8000;
    send_matrix(m);
    for (int i = 0; i < 8; i++) begin
      foreach (m.a[k]) m.a[k] = rand_elem(3);
      send_matrix(m);
    end
  endtask

  task automatic test_random(int count);
    matrix_t m;
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 3);
      foreach (m.a[k]) m.a[k] = rand_elem($urandom_range(0, 4) == 0 ? 0 : kind);
      // Sometimes copy a row so the determinant is exactly zero.
      if ($urandom_range(0, 9) == 0)
        for (int c = 0; c < 3; c++) m.a[6+c] = m.a[c];
      send_matrix(m);
    end
  endtask

  // Result side: random stalls, compare each word with the oldest prediction.
  always @(posedge clk) begin
    inverse_t want;
    logic [EW-1:0] got [NE];
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.inv_r0c0, out_ch.inv_r0c1, out_ch.inv_r0c2,
              out_ch.inv_r1c0, out_ch.inv_r1c1, out_ch.inv_r1c2,
              out_ch.inv_r2c0, out_ch.inv_r2c1, out_ch.inv_r2c2};
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected_word", 0, got[0], '0);
      end else begin
        want = expected_q.pop_front();
        for (int k = 0; k < NE; k++)
          if (got[k] !== want.inv[k]) report_mismatch("inv", k, got[k], want.inv[k]);
        if (out_ch.singular !== want.singular)
          report_mismatch("singular", 0, out_ch.singular, want.singular);
        if (out_ch.saturated !== want.saturated)
          report_mismatch("saturated", 0, out_ch.saturated, want.saturated);
      end
    end
  end

  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (out_ch.valid && out_ch.ready || !out_ch.ready && stall_left == 0) begin
      if (out_ch.valid && out_ch.ready && ($urandom_range(0, 2) != 0)) begin
        stall_left <= $urandom_range(0, 9);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  initial begin
    fail_count = 0;
    sent_count = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.a_r0c0 = '0; in_ch.a_r0c1 = '0; in_ch.a_r0c2 = '0;
    in_ch.a_r1c0 = '0; in_ch.a_r1c1 = '0; in_ch.a_r1c2 = '0;
    in_ch.a_r2c0 = '0; in_ch.a_r2c1 = '0; in_ch.a_r2c2 = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1200);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2 * EW + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/matinv_pkg.sv
hw/rtl/matinv_in_if.sv
hw/rtl/matinv_out_if.sv
hw/rtl/matinv_div_pipe.sv
hw/rtl/matrix_inverse_3x3_unit.sv
dv/matinv_tb_pkg.sv
dv/testbench.sv
